/* rtl/u8rep_pkg.sv */
// ----------------------------------------------------------------------------
// u8rep_pkg
// Shared types and constants for the utf-8 repair stream block: channel
// payload structs, controller/datapath command and status, byte codes.
// ----------------------------------------------------------------------------
package u8rep_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    // result transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // take the input byte, update state, build output plan
        logic advance;  // current output byte was taken
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic plan_nonempty;  // plan built from the current input has output
        logic pending;        // output bytes still queued
        logic final_byte;     // current output byte is the last one queued
    } dp_stat_t;

    // replacement character U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // continuation byte range
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    // lead bytes with a narrowed second byte range
    localparam logic [7:0] LEAD_E0 = 8'hE0;  // no overlong 3-byte forms
    localparam logic [7:0] LEAD_ED = 8'hED;  // no surrogates
    localparam logic [7:0] LEAD_F0 = 8'hF0;  // no overlong 4-byte forms
    localparam logic [7:0] LEAD_F4 = 8'hF4;  // nothing above U+10FFFF
    localparam logic [7:0] E0_LO   = 8'hA0;
    localparam logic [7:0] ED_HI   = 8'h9F;
    localparam logic [7:0] F0_LO   = 8'h90;
    localparam logic [7:0] F4_HI   = 8'h8F;

    // lead byte classes
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    // byte position inside a replacement character
    localparam logic [1:0] SUB_B0 = 2'd0;
    localparam logic [1:0] SUB_B1 = 2'd1;
    localparam logic [1:0] SUB_B2 = 2'd2;

endpackage

/* rtl/u8rep_dp.sv */
// ----------------------------------------------------------------------------
// u8rep_dp
// Datapath: sequence state (held bytes, counts), per-transaction output plan
// and the byte emitter that walks the plan one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module u8rep_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  u8rep_pkg::in_t      in_data,
    input  u8rep_pkg::ctl_cmd_t cmd,
    output u8rep_pkg::dp_stat_t stat,
    output u8rep_pkg::out_t     out_data
);

    // sequence state
    logic [7:0] held_reg [3];
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [1:0] need_reg, need_next;

    // output plan: leading replacements, literal bytes, trailing replacement
    logic [1:0] reps_a_reg, reps_a_next;
    logic [7:0] lit_reg [4];
    logic [7:0] lit_next [4];
    logic [2:0] lit_cnt_reg, lit_cnt_next;
    logic [1:0] lit_idx_reg;
    logic       rep_b_reg, rep_b_next;
    logic       last_reg;
    logic [1:0] sub_reg;

    logic [7:0] b;
    logic [7:0] lo, hi;
    logic       cont_ok;
    logic       store_cont;
    logic       wr_en;
    logic [1:0] wr_idx;
    logic [1:0] lit_held;
    logic [1:0] fresh_need;
    logic       is_lead;

    assign b = in_data.text_byte;

    // allowed range for the next continuation byte
    always_comb begin
        lo = u8rep_pkg::CONT_LO;
        hi = u8rep_pkg::CONT_HI;
        if (held_cnt_reg == 2'd1) begin
            unique case (held_reg[0])
                u8rep_pkg::LEAD_E0: lo = u8rep_pkg::E0_LO;
                u8rep_pkg::LEAD_ED: hi = u8rep_pkg::ED_HI;
                u8rep_pkg::LEAD_F0: lo = u8rep_pkg::F0_LO;
                u8rep_pkg::LEAD_F4: hi = u8rep_pkg::F4_HI;
                default: ;
            endcase
        end
    end

    assign cont_ok = (held_cnt_reg != 2'd0) && (b >= lo) && (b <= hi);

    // lead byte classification for a fresh start
    always_comb begin
        is_lead    = 1'b1;
        fresh_need = 2'd0;
        priority if (b >= u8rep_pkg::LEAD2_LO && b <= u8rep_pkg::LEAD2_HI) begin
            fresh_need = 2'd1;
        end else if (b >= u8rep_pkg::LEAD3_LO && b <= u8rep_pkg::LEAD3_HI) begin
            fresh_need = 2'd2;
        end else if (b >= u8rep_pkg::LEAD4_LO && b <= u8rep_pkg::LEAD4_HI) begin
            fresh_need = 2'd3;
        end else begin
            is_lead = 1'b0;
        end
    end

    // plan and next sequence state for the byte on the input
    always_comb begin
        held_cnt_next = held_cnt_reg;
        need_next     = need_reg;
        store_cont    = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = held_cnt_reg;
        lit_held      = 2'd0;
        reps_a_next   = 2'd0;
        lit_cnt_next  = 3'd0;
        rep_b_next    = 1'b0;
        if (cont_ok && need_reg <= 2'd1) begin
            // sequence complete: pass held bytes and this one
            lit_held      = held_cnt_reg;
            lit_cnt_next  = {1'b0, held_cnt_reg} + 3'd1;
            held_cnt_next = 2'd0;
            need_next     = 2'd0;
        end else if (cont_ok && held_cnt_reg != 2'd3) begin
            // continuation, more to come
            store_cont    = 1'b1;
            wr_en         = 1'b1;
            held_cnt_next = held_cnt_reg + 2'd1;
            need_next     = need_reg - 2'd1;
        end else begin
            // broken or nothing held: one replacement per held byte
            reps_a_next   = held_cnt_reg;
            held_cnt_next = 2'd0;
            need_next     = 2'd0;
            if (!b[7]) begin
                lit_cnt_next = 3'd1;
            end else if (is_lead) begin
                wr_en         = 1'b1;
                wr_idx        = 2'd0;
                held_cnt_next = 2'd1;
                need_next     = fresh_need;
            end else begin
                rep_b_next = 1'b1;
            end
        end
        // end of text flushes whatever is still unfinished
        if (in_data.end_of_text && held_cnt_next != 2'd0) begin
            if (store_cont) begin
                reps_a_next = held_cnt_next;
            end else begin
                rep_b_next = 1'b1;
            end
            held_cnt_next = 2'd0;
            need_next     = 2'd0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lit_next[i] = (2'(i) < lit_held) ? held_reg[i] : b;
        end
        lit_next[3] = b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
            need_reg     <= 2'd0;
        end else if (cmd.load) begin
            held_cnt_reg <= held_cnt_next;
            need_reg     <= need_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && wr_en) begin
            held_reg[wr_idx] <= b;
        end
        if (cmd.load) begin
            for (int i = 0; i < 4; i++) begin
                lit_reg[i] <= lit_next[i];
            end
            last_reg <= in_data.end_of_text;
        end
    end

    // emitter
    logic in_rep_a;
    logic in_lit;

    assign in_rep_a = (reps_a_reg != 2'd0);
    assign in_lit   = !in_rep_a && (lit_cnt_reg != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reps_a_reg  <= 2'd0;
            lit_cnt_reg <= 3'd0;
            lit_idx_reg <= 2'd0;
            rep_b_reg   <= 1'b0;
            sub_reg     <= u8rep_pkg::SUB_B0;
        end else if (cmd.load) begin
            reps_a_reg  <= reps_a_next;
            lit_cnt_reg <= lit_cnt_next;
            lit_idx_reg <= 2'd0;
            rep_b_reg   <= rep_b_next;
            sub_reg     <= u8rep_pkg::SUB_B0;
        end else if (cmd.advance) begin
            if (in_lit) begin
                lit_idx_reg <= lit_idx_reg + 2'd1;
                lit_cnt_reg <= lit_cnt_reg - 3'd1;
            end else if (sub_reg == u8rep_pkg::SUB_B2) begin
                sub_reg <= u8rep_pkg::SUB_B0;
                if (in_rep_a) begin
                    reps_a_reg <= reps_a_reg - 2'd1;
                end else begin
                    rep_b_reg <= 1'b0;
                end
            end else begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
    end

    logic [7:0] rep_byte;
    logic       final_byte;

    always_comb begin
        unique case (sub_reg)
            u8rep_pkg::SUB_B0: rep_byte = u8rep_pkg::REPL_B0;
            u8rep_pkg::SUB_B1: rep_byte = u8rep_pkg::REPL_B1;
            default:           rep_byte = u8rep_pkg::REPL_B2;
        endcase
    end

    always_comb begin
        priority if (in_rep_a) begin
            final_byte = (reps_a_reg == 2'd1) && (sub_reg == u8rep_pkg::SUB_B2)
                         && (lit_cnt_reg == 3'd0) && !rep_b_reg;
        end else if (in_lit) begin
            final_byte = (lit_cnt_reg == 3'd1) && !rep_b_reg;
        end else begin
            final_byte = (sub_reg == u8rep_pkg::SUB_B2);
        end
    end

    assign out_data.out_byte = in_lit ? lit_reg[lit_idx_reg] : rep_byte;
    assign out_data.out_last = last_reg && final_byte;

    assign stat.plan_nonempty = (reps_a_next != 2'd0) || (lit_cnt_next != 3'd0) || rep_b_next;
    assign stat.pending       = in_rep_a || (lit_cnt_reg != 3'd0) || rep_b_reg;
    assign stat.final_byte    = final_byte;

endmodule

/* rtl/u8rep_ctrl.sv */
// ----------------------------------------------------------------------------
// u8rep_ctrl
// Controller: decides when an input transaction is taken and when output
// bytes are presented; drives load/advance commands to the datapath.
// ----------------------------------------------------------------------------
module u8rep_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  u8rep_pkg::dp_stat_t stat,
    output u8rep_pkg::ctl_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic state_reg, state_next;

    assign m_valid     = (state_reg == ST_SEND);
    // next byte is taken in idle or as the final queued byte leaves
    assign s_ready     = (state_reg == ST_IDLE) || (m_ready && stat.final_byte);
    assign cmd.load    = s_valid && s_ready;
    assign cmd.advance = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        if (cmd.load) begin
            state_next = stat.plan_nonempty ? ST_SEND : ST_IDLE;
        end else if (cmd.advance && stat.final_byte) begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sending implies the datapath has bytes queued
    a_send_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> stat.pending)
        else $error("send state with empty output queue");

    // while sending, input is only taken with the final byte
    a_take_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && s_ready) |-> (m_ready && stat.final_byte))
        else $error("input taken before output queue drained");

    // a transaction with no output leaves the block idle
    a_empty_plan_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && !stat.plan_nonempty) |=> (state_reg == ST_IDLE))
        else $error("idle expected after transaction without output");

    // a transaction with output is presented in the next cycle
    a_plan_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && stat.plan_nonempty) |=> (m_valid && stat.pending))
        else $error("queued output not presented");

endmodule

/* rtl/utf8_repair_stream.sv */
// ----------------------------------------------------------------------------
// utf8_repair_stream
// Streaming utf-8 checker that passes valid sequences and replaces broken
// or stray bytes with U+FFFD.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one text byte per transaction, end_of_text on the final byte
//   m_ channel: repaired bytes, out_last on the final output byte of a string
//   ascii bytes are presented in the cycle after they are taken; a valid multi-byte
//   sequence is held (no output) until its last byte arrives, then all of its
//   bytes leave one per cycle while the receiver is ready
//   a broken sequence yields EF BF BD per held byte, plus the new byte, its own
//   replacement or nothing for a new lead: up to 12 output bytes per input transaction
//   throughput: one input transaction per cycle for ascii and held bytes while
//   the receiver is ready; a transaction that produces output bytes holds the
//   single output port until all are accepted, and the next input is taken on
//   the cycle the last of them is accepted
//   receiver stall: output byte and flags hold; input is not taken until the
//   queued bytes drain
//   reset (aresetn low, synchronous): drops held bytes and any queued output,
//   block is idle and ready in the first cycle after reset
// ----------------------------------------------------------------------------
module utf8_repair_stream (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  u8rep_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output u8rep_pkg::out_t  m_data
);

    // command/status between controller and datapath
    u8rep_pkg::ctl_cmd_t cmd;
    u8rep_pkg::dp_stat_t stat;

    // controller: handshakes, idle/send sequencing
    u8rep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: sequence checking, held bytes, output plan and emitter
    u8rep_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_data)
    );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_repair_stream. Text strings go in one byte per
// transaction. A scoreboard class tracks the utf-8 decode state and lists the
// repaired bytes each input should produce. It compares every output
// transaction against them in order. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import u8rep_pkg::*;

    // ------------------------------------------------------------------------
    // expected repaired byte stream and the decode state behind it
    // ------------------------------------------------------------------------
    class repair_scoreboard;

        out_t        expected_bytes[$];  // repaired bytes not yet seen on m_
        out_t        step_bytes[$];      // bytes caused by the current input
        logic [7:0]  seq_bytes[3];       // lead and continuation bytes so far
        int unsigned seq_len;
        int unsigned cont_missing;
        int unsigned mismatches;

        function new();
            seq_len      = 0;
            cont_missing = 0;
            mismatches   = 0;
            foreach (seq_bytes[i]) seq_bytes[i] = '0;
        endfunction

        function void put_byte(logic [7:0] b);
            out_t o;
            o.out_byte = b;
            o.out_last = 1'b0;
            step_bytes.push_back(o);
        endfunction

        function void put_replacement();
            put_byte(REPL_B0);
            put_byte(REPL_B1);
            put_byte(REPL_B2);
        endfunction

        // every held byte of a broken sequence turns into its own U+FFFD
        function void drop_sequence();
            repeat (seq_len) put_replacement();
            seq_len      = 0;
            cont_missing = 0;
        endfunction

        function void begin_fresh(logic [7:0] b);
            int unsigned need;
            need = 0;
            if (b < CONT_LO) begin
                put_byte(b);
                return;
            end
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                need = 1;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                need = 2;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                need = 3;
            end
            if (need == 0) begin
                put_replacement();
            end else begin
                seq_bytes[0] = b;
                seq_len      = 1;
                cont_missing = need;
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [7:0] lo;
            logic [7:0] hi;
            if (seq_len != 0) begin
                lo = CONT_LO;
                hi = CONT_HI;
                // second byte ranges narrowed against overlongs, surrogates, > U+10FFFF
                if (seq_len == 1) begin
                    case (seq_bytes[0])
                        LEAD_E0: lo = E0_LO;
                        LEAD_ED: hi = ED_HI;
                        LEAD_F0: lo = F0_LO;
                        LEAD_F4: hi = F4_HI;
                        default: ;
                    endcase
                end
                if (b >= lo && b <= hi) begin
                    if (cont_missing <= 1) begin
                        for (int i = 0; i < seq_len; i++) put_byte(seq_bytes[i]);
                        put_byte(b);
                        seq_len      = 0;
                        cont_missing = 0;
                    end else begin
                        seq_bytes[seq_len] = b;
                        seq_len++;
                        cont_missing--;
                    end
                    return;
                end
                drop_sequence();
            end
            begin_fresh(b);
        endfunction

        // accepted input transaction: work out the repaired bytes it causes
        function void note_text_byte(in_t item);
            step_bytes.delete();
            decode_byte(item.text_byte);
            if (item.end_of_text) begin
                drop_sequence();
                foreach (seq_bytes[i]) seq_bytes[i] = '0;
                if (step_bytes.size() > 0) step_bytes[$].out_last = 1'b1;
            end
            foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
        endfunction

        // accepted output transaction: compare with the oldest expectation
        function void check_out_byte(out_t got);
            out_t want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output, expected none, got byte %h last %b",
                         $time, got.out_byte, got.out_last);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte mismatch, expected %h, got %h",
                         $time, want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.out_last !== want.out_last) begin
                $display("%0t: out_last mismatch, expected %b, got %b",
                         $time, want.out_last, got.out_last);
                mismatches++;
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf8_repair_stream dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    repair_scoreboard board;
    in_t              text_q[$];     // every input transaction of the run
    logic [7:0]       str_bytes[$];  // string under construction
    bit               steady_flow;   // no idling on either side while set

    // ------------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------------

    // close the current string: end_of_text on its final byte
    function automatic void queue_string();
        in_t item;
        foreach (str_bytes[i]) begin
            item.text_byte   = str_bytes[i];
            item.end_of_text = (i == str_bytes.size() - 1);
            text_q.push_back(item);
        end
        str_bytes.delete();
    endfunction

    function automatic logic [7:0] any_cont();
        return 8'($urandom_range(CONT_LO, CONT_HI));
    endfunction

    // one code point, mostly well formed, sometimes truncated or corrupted,
    // sometimes plain noise
    function automatic void add_token();
        logic [7:0]  seq[$];
        logic [7:0]  lead;
        int unsigned roll;
        int unsigned n_drop;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            seq.push_back(8'($urandom_range(1, 127)));
        end else if (roll < 45) begin
            seq.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            seq.push_back(any_cont());
        end else if (roll < 70) begin
            lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            seq.push_back(lead);
            if (lead == LEAD_E0) begin
                seq.push_back(8'($urandom_range(E0_LO, CONT_HI)));
            end else if (lead == LEAD_ED) begin
                seq.push_back(8'($urandom_range(CONT_LO, ED_HI)));
            end else begin
                seq.push_back(any_cont());
            end
            seq.push_back(any_cont());
        end else if (roll < 88) begin
            lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
            seq.push_back(lead);
            if (lead == LEAD_F0) begin
                seq.push_back(8'($urandom_range(F0_LO, CONT_HI)));
            end else if (lead == LEAD_F4) begin
                seq.push_back(8'($urandom_range(CONT_LO, F4_HI)));
            end else begin
                seq.push_back(any_cont());
            end
            seq.push_back(any_cont());
            seq.push_back(any_cont());
        end else begin
            seq.push_back(8'($urandom_range(1, 255)));
        end
        // break some sequences: cut short, or one byte replaced by noise
        roll = $urandom_range(0, 99);
        if (roll < 12 && seq.size() > 1) begin
            n_drop = $urandom_range(1, seq.size() - 1);
            repeat (n_drop) void'(seq.pop_back());
        end else if (roll < 22) begin
            seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(1, 255));
        end
        foreach (seq[i]) str_bytes.push_back(seq[i]);
    endfunction

    // ------------------------------------------------------------------------
    // input side: valid never waits for ready, payload holds until taken
    // ------------------------------------------------------------------------
    task automatic send_text_byte(input in_t item);
        while (!steady_flow && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_text_byte(item);
    endtask

    // ------------------------------------------------------------------------
    // output side: check each transaction, stall ready at random
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_out_byte(m_data);
        end
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 36);
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        board       = new();
        steady_flow = 1'b0;

        // directed strings
        // ascii extremes, valid 2-, 3-byte forms incl. the narrowed E0 range
        str_bytes = '{8'h01, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80};
        queue_string();
        // surrogate: ED lead broken by A0, which is then a stray byte
        str_bytes = '{8'hED, 8'hA0, 8'h41};
        queue_string();
        // above U+10FFFF, invalid leads C0 and FF, stray continuation
        str_bytes = '{8'hF4, 8'h90, 8'hC0, 8'hFF, 8'h80};
        queue_string();
        // three held bytes broken by C1 at end of text: twelve output bytes
        str_bytes = '{8'hF0, 8'h90, 8'h80, 8'hC1};
        queue_string();
        // largest valid code point, zero byte passes as ascii,
        // lone lead flushed at end of text
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'hE0};
        queue_string();

        // random strings of a few code points each
        while (text_q.size() < 440) begin
            repeat ($urandom_range(1, 6)) add_token();
            queue_string();
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (text_q[i]) begin
            // a long stretch with both sides streaming flat out
            steady_flow = (i >= 200 && i < 300);
            send_text_byte(text_q[i]);
        end
        s_valid     <= 1'b0;
        steady_flow = 1'b0;

        // drain, then give stray outputs a chance to show up
        while (board.expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/u8rep_pkg.sv
rtl/u8rep_dp.sv
rtl/u8rep_ctrl.sv
rtl/utf8_repair_stream.sv
tb/tb_top.sv
